>>> rtl/environmental_sensor_compensation_defines.svh
// assertion macros for the sensor compensation checker
// no dependencies; included by the checker file only
`ifndef ENVIRONMENTAL_SENSOR_COMPENSATION_DEFINES_SVH
`define ENVIRONMENTAL_SENSOR_COMPENSATION_DEFINES_SVH

// clocked assertion with reset disable
`define ESC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, but also checked while reset is low
`define ESC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/esc_pkg.sv
// shared types, codes and helpers for the sensor compensation block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 64;
    localparam int DivCntW  = 5;

    localparam logic [1:0] CMD_TEMP  = 2'd0;
    localparam logic [1:0] CMD_PRESS = 2'd1;
    localparam logic [1:0] CMD_HUM   = 2'd2;

    localparam logic [CfgIdxW-1:0] REG_TEMP    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PRESS_A = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_PRESS_B = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_PRESS_9 = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_HUM     = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [19:0] raw_reading;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] measurement;
        logic               divide_fault;
    } out_item_t;

    typedef enum logic [5:0] {
        OP_NOP, OP_LOAD,
        OP_T0, OP_T1, OP_T2, OP_T3,
        OP_P0, OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_P6,
        OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END,
        OP_P8, OP_P9, OP_P10, OP_P11,
        OP_H0, OP_H1, OP_H2, OP_H3, OP_H4, OP_H5, OP_H6, OP_H7,
        OP_ZERO, OP_FAULT
    } op_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_T0, ST_T1, ST_T2, ST_T3,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
        ST_DIV_INIT, ST_DIV, ST_DIV_END,
        ST_P8, ST_P9, ST_P10, ST_P11,
        ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7,
        ST_ZERO, ST_FAULT
    } state_t;

    typedef struct packed {
        op_t op;
    } esc_cmd_t;

    typedef struct packed {
        logic div_zero;
    } esc_stat_t;

    // arithmetic shift right of a 32-bit pattern
    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        return 32'($signed(x) >>> n);
    endfunction

endpackage

`default_nettype wire

>>> rtl/esc_ctrl.sv
// sequencer for the sensor compensation block
// depends on esc_pkg
`timescale 1ns / 1ps
`default_nettype none

module esc_ctrl
    import esc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_cmd,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output esc_cmd_t        ctl,
    input  wire esc_stat_t  stat
);

    state_t state_reg, state_next;
    logic [DivCntW-1:0] cnt_reg, cnt_next;
    logic ov_reg, ov_next;
    logic out_free;
    logic fin;

    assign out_free  = !ov_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_cmd)
                        CMD_TEMP:  state_next = ST_T0;
                        CMD_PRESS: state_next = ST_P0;
                        CMD_HUM:   state_next = ST_H0;
                        default:   state_next = ST_ZERO;
                    endcase
                end
            end
            ST_T0: state_next = ST_T1;
            ST_T1: state_next = ST_T2;
            ST_T2: state_next = ST_T3;
            ST_P0: state_next = ST_P1;
            ST_P1: state_next = ST_P2;
            ST_P2: state_next = ST_P3;
            ST_P3: state_next = ST_P4;
            ST_P4: state_next = ST_P5;
            ST_P5: state_next = ST_P6;
            ST_P6: state_next = stat.div_zero ? ST_FAULT : ST_DIV_INIT;
            ST_DIV_INIT:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                    state_next = ST_DIV_END;
            end
            ST_DIV_END: state_next = ST_P8;
            ST_P8:  state_next = ST_P9;
            ST_P9:  state_next = ST_P10;
            ST_P10: state_next = ST_P11;
            ST_H0:  state_next = ST_H1;
            ST_H1:  state_next = ST_H2;
            ST_H2:  state_next = ST_H3;
            ST_H3:  state_next = ST_H4;
            ST_H4:  state_next = ST_H5;
            ST_H5:  state_next = ST_H6;
            ST_H6:  state_next = ST_H7;
            ST_T3, ST_P11, ST_H7, ST_ZERO, ST_FAULT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.op = OP_NOP;
        fin    = 1'b0;
        unique case (state_reg)
            ST_IDLE:     ctl.op = in_valid ? OP_LOAD : OP_NOP;
            ST_T0:       ctl.op = OP_T0;
            ST_T1:       ctl.op = OP_T1;
            ST_T2:       ctl.op = OP_T2;
            ST_P0:       ctl.op = OP_P0;
            ST_P1:       ctl.op = OP_P1;
            ST_P2:       ctl.op = OP_P2;
            ST_P3:       ctl.op = OP_P3;
            ST_P4:       ctl.op = OP_P4;
            ST_P5:       ctl.op = OP_P5;
            ST_P6:       ctl.op = stat.div_zero ? OP_NOP : OP_P6;
            ST_DIV_INIT: ctl.op = OP_DIV_INIT;
            ST_DIV:      ctl.op = OP_DIV_STEP;
            ST_DIV_END:  ctl.op = OP_DIV_END;
            ST_P8:       ctl.op = OP_P8;
            ST_P9:       ctl.op = OP_P9;
            ST_P10:      ctl.op = OP_P10;
            ST_H0:       ctl.op = OP_H0;
            ST_H1:       ctl.op = OP_H1;
            ST_H2:       ctl.op = OP_H2;
            ST_H3:       ctl.op = OP_H3;
            ST_H4:       ctl.op = OP_H4;
            ST_H5:       ctl.op = OP_H5;
            ST_H6:       ctl.op = OP_H6;
            ST_T3:       begin fin = out_free; ctl.op = out_free ? OP_T3 : OP_NOP; end
            ST_P11:      begin fin = out_free; ctl.op = out_free ? OP_P11 : OP_NOP; end
            ST_H7:       begin fin = out_free; ctl.op = out_free ? OP_H7 : OP_NOP; end
            ST_ZERO:     begin fin = out_free; ctl.op = out_free ? OP_ZERO : OP_NOP; end
            ST_FAULT:    begin fin = out_free; ctl.op = out_free ? OP_FAULT : OP_NOP; end
            default:     ctl.op = OP_NOP;
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        if (fin)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/esc_dp.sv
// datapath: coefficient registers, shared multiplier, serial divider
// depends on esc_pkg
`timescale 1ns / 1ps
`default_nettype none

module esc_dp
    import esc_pkg::*;
(
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire in_item_t            in_data,
    input  wire esc_cmd_t            ctl,
    output esc_stat_t                stat,
    output out_item_t                out_data
);

    logic [47:0] temp_reg;
    logic [63:0] pa_reg, pb_reg, hum_reg;
    logic [15:0] p9_reg;
    logic [31:0] ft_reg, ft_next;
    logic [19:0] raw_reg;
    logic [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, q_reg, q_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [31:0] rem_reg, rem_next;
    logic        flag_reg, flag_next;
    logic [31:0] res_reg, res_next;
    logic        flt_reg, flt_next;
    logic [31:0] mul_a, mul_b, prod;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] v1c, xc, tmp;
    logic [32:0] rem_sh;

    // coefficient fields
    assign t1 = {16'b0, temp_reg[15:0]};
    assign t2 = {{16{temp_reg[31]}}, temp_reg[31:16]};
    assign t3 = {{16{temp_reg[47]}}, temp_reg[47:32]};
    assign p1 = {16'b0, pa_reg[15:0]};
    assign p2 = {{16{pa_reg[31]}}, pa_reg[31:16]};
    assign p3 = {{16{pa_reg[47]}}, pa_reg[47:32]};
    assign p4 = {{16{pa_reg[63]}}, pa_reg[63:48]};
    assign p5 = {{16{pb_reg[15]}}, pb_reg[15:0]};
    assign p6 = {{16{pb_reg[31]}}, pb_reg[31:16]};
    assign p7 = {{16{pb_reg[47]}}, pb_reg[47:32]};
    assign p8 = {{16{pb_reg[63]}}, pb_reg[63:48]};
    assign p9 = {{16{p9_reg[15]}}, p9_reg};
    assign h1 = {24'b0, hum_reg[7:0]};
    assign h2 = {{16{hum_reg[23]}}, hum_reg[23:8]};
    assign h3 = {24'b0, hum_reg[31:24]};
    assign h4 = {{20{hum_reg[43]}}, hum_reg[43:32]};
    assign h5 = {{20{hum_reg[55]}}, hum_reg[55:44]};
    assign h6 = {{24{hum_reg[63]}}, hum_reg[63:56]};

    assign v1c = asr(ft_reg, 1) - 32'd64000;
    assign xc  = ft_reg - 32'd76800;
    assign prod = mul_a * mul_b;
    assign rem_sh = {rem_reg, dvd_reg[31]};

    assign stat.div_zero = (c_reg == '0);
    assign out_data.measurement  = res_reg;
    assign out_data.divide_fault = flt_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctl.op)
            OP_T0:
            begin
                mul_a = {15'b0, raw_reg[19:3]} - {15'b0, temp_reg[15:0], 1'b0};
                mul_b = t2;
            end
            OP_T1:
            begin
                mul_a = {16'b0, raw_reg[19:4]} - t1;
                mul_b = {16'b0, raw_reg[19:4]} - t1;
            end
            OP_T2:  begin mul_a = b_reg; mul_b = t3; end
            OP_T3:  begin mul_a = ft_reg; mul_b = 32'd5; end
            OP_P0:  begin mul_a = asr(v1c, 2); mul_b = asr(v1c, 2); end
            OP_P1:  begin mul_a = asr(q_reg, 11); mul_b = p6; end
            OP_P2:  begin mul_a = a_reg; mul_b = p5; end
            OP_P3:  begin mul_a = p3; mul_b = asr(q_reg, 13); end
            OP_P4:  begin mul_a = p2; mul_b = a_reg; end
            OP_P5:  begin mul_a = 32'd32768 + c_reg; mul_b = p1; end
            OP_P6:
            begin
                mul_a = (32'd1048576 - {12'b0, raw_reg}) - asr(b_reg, 12);
                mul_b = 32'd3125;
            end
            OP_P8:  begin mul_a = q_reg >> 3; mul_b = q_reg >> 3; end
            OP_P9:  begin mul_a = p9; mul_b = a_reg; end
            OP_P10: begin mul_a = q_reg >> 2; mul_b = p8; end
            OP_H0:  begin mul_a = h5; mul_b = xc; end
            OP_H1:  begin mul_a = q_reg; mul_b = h6; end
            OP_H2:  begin mul_a = q_reg; mul_b = h3; end
            OP_H3:  begin mul_a = b_reg; mul_b = c_reg; end
            OP_H4:  begin mul_a = b_reg; mul_b = h2; end
            OP_H5:  begin mul_a = a_reg; mul_b = b_reg; end
            OP_H6:  begin mul_a = asr(q_reg, 15); mul_b = asr(q_reg, 15); end
            OP_H7:  begin mul_a = c_reg; mul_b = h1; end
            default: ;
        endcase
    end

    always_comb
    begin
        ft_next   = ft_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        q_next    = q_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        flag_next = flag_reg;
        res_next  = res_reg;
        flt_next  = flt_reg;
        tmp       = '0;
        case (ctl.op)
            OP_T0: a_next  = asr(prod, 11);
            OP_T1: b_next  = asr(prod, 12);
            OP_T2: ft_next = a_reg + asr(prod, 14);
            OP_T3:
            begin
                res_next = asr(prod + 32'd128, 8);
                flt_next = 1'b0;
            end
            OP_P0: begin a_next = v1c; q_next = prod; end
            OP_P1: b_next = prod;
            OP_P2: b_next = b_reg + (prod << 1);
            OP_P3:
            begin
                b_next = asr(b_reg, 2) + (p4 << 16);
                c_next = asr(prod, 3);
            end
            OP_P4: c_next = asr(c_reg + asr(prod, 1), 18);
            OP_P5: c_next = asr(prod, 15);
            OP_P6: q_next = prod;
            OP_DIV_INIT:
            begin
                flag_next = q_reg[31];
                dvd_next  = q_reg[31] ? q_reg : (q_reg << 1);
                rem_next  = '0;
            end
            OP_DIV_STEP:
            begin
                // remainder stays below the divisor, so 32 bits hold it
                if (rem_sh >= {1'b0, c_reg})
                begin
                    rem_next = rem_sh[31:0] - c_reg;
                    dvd_next = {dvd_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[31:0];
                    dvd_next = {dvd_reg[30:0], 1'b0};
                end
            end
            OP_DIV_END: q_next = flag_reg ? (dvd_reg << 1) : dvd_reg;
            OP_P8:  a_next = prod >> 13;
            OP_P9:  a_next = asr(prod, 12);
            OP_P10: b_next = asr(prod, 13);
            OP_P11:
            begin
                res_next = q_reg + asr(a_reg + b_reg + p7, 4);
                flt_next = 1'b0;
            end
            OP_H0:
            begin
                q_next = xc;
                a_next = asr(({12'b0, raw_reg[15:0], 4'b0} << 10) - (h4 << 20)
                             - prod + 32'd16384, 15);
            end
            OP_H1: b_next = asr(prod, 10);
            OP_H2: c_next = asr(prod, 11) + 32'd32768;
            OP_H3: b_next = asr(prod, 10) + 32'd2097152;
            OP_H4: b_next = asr(prod + 32'd8192, 14);
            OP_H5: q_next = prod;
            OP_H6: c_next = asr(prod, 7);
            OP_H7:
            begin
                tmp = q_reg - asr(prod, 4);
                if (tmp[31])
                    tmp = '0;
                if (tmp > 32'd419430400)
                    tmp = 32'd419430400;
                res_next = tmp >> 12;
                flt_next = 1'b0;
            end
            OP_ZERO:  begin res_next = '0; flt_next = 1'b0; end
            OP_FAULT: begin res_next = '0; flt_next = 1'b1; end
            default: ;
        endcase
    end

    // fine temperature and coefficients are architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ft_reg   <= '0;
            temp_reg <= '0;
            pa_reg   <= '0;
            pb_reg   <= '0;
            p9_reg   <= '0;
            hum_reg  <= '0;
        end
        else
        begin
            ft_reg <= ft_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TEMP:    temp_reg <= cfg_data[47:0];
                    REG_PRESS_A: pa_reg   <= cfg_data;
                    REG_PRESS_B: pb_reg   <= cfg_data;
                    REG_PRESS_9: p9_reg   <= cfg_data[15:0];
                    REG_HUM:     hum_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_LOAD)
            raw_reg <= in_data.raw_reading;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        q_reg    <= q_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        flag_reg <= flag_next;
        res_reg  <= res_next;
        flt_reg  <= flt_next;
    end

endmodule

`default_nettype wire

>>> rtl/environmental_sensor_compensation.sv
// top level of the environmental sensor compensation block
// depends on esc_pkg, esc_ctrl, esc_dp
//
// usage:
//  - in channel (in_valid/in_ready/in_data) carries one request: a reading
//    kind and a 20-bit raw converter value
//  - out channel (out_valid/out_ready/out_data) returns one result per request:
//    the compensated measurement and a divide fault flag
//  - cfg_we/cfg_index/cfg_data write the calibration words; write only while idle
//  - each request runs its steps in turn through the one shared 32x32
//    multiplier; a pressure request also runs the bit-serial divider, one
//    quotient bit per cycle, unless its divisor is zero
//  - one request is worked at a time; in_ready is high only while the
//    sequencer is idle, and the next request is taken while a result waits
//  - a stalled receiver holds the finished request in its last step until the
//    output register frees up
//  - reset clears coefficients and the stored fine temperature to zero
//  - a pressure request with a zero divisor returns 0 with divide_fault set
`timescale 1ns / 1ps
`default_nettype none

module environmental_sensor_compensation
    import esc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire in_item_t            in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output out_item_t                out_data,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data
);

    // command and status between sequencer and datapath
    esc_cmd_t  ctl;
    esc_stat_t stat;

    esc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (in_data.cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl),
        .stat      (stat)
    );

    esc_dp u_dp (
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .ctl       (ctl),
        .stat      (stat),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

>>> rtl/esc_checker.sv
// port-level checker for the sensor compensation block, bound to the top
// depends on esc_pkg and environmental_sensor_compensation_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "environmental_sensor_compensation_defines.svh"

module esc_checker
    import esc_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);

    // stalled result holds
    `ESC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

    // a fault always comes with a zero measurement
    `ESC_ASSERT(a_fault_zero, out_valid && out_data.divide_fault |-> out_data.measurement == 0, "fault with nonzero value")

    // one request at a time
    `ESC_ASSERT(a_one_req, in_valid && in_ready |=> !in_ready, "second request taken while busy")

    // no result can appear in the cycle right after a request is taken
    `ESC_ASSERT(a_no_early, in_valid && in_ready && !out_valid |=> !out_valid, "result too early")

    // nothing is shown during reset
    `ESC_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind environmental_sensor_compensation esc_checker u_esc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
